@@ rtl/core/high_side_switch_channel_monitor_core_defines.svh @@
// ----------------------------------------------------------------------------
// switch channel monitor assertion macros
// shared property shorthands for the monitor core
// ----------------------------------------------------------------------------
`ifndef HIGH_SIDE_SWITCH_CHANNEL_MONITOR_CORE_DEFINES_SVH
`define HIGH_SIDE_SWITCH_CHANNEL_MONITOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define HSSC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("hssc assertion failed");
`define HSSC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("hssc assertion failed");
`else
`define HSSC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define HSSC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ rtl/core/hssc_pkg.sv @@
// ----------------------------------------------------------------------------
// switch channel monitor package
// types, codes and constants shared by the monitor core modules
// ----------------------------------------------------------------------------
`default_nettype none

package hssc_pkg;

    localparam int unsigned NUM_CHANNELS        = 20;
    localparam int unsigned CHANNELS_PER_DEVICE = 4;
    localparam int unsigned NUM_DEVICES         = 5;
    localparam int unsigned CH_IDX_W            = $clog2(NUM_CHANNELS);
    localparam int unsigned DEV_IDX_W           = $clog2(NUM_DEVICES);

    localparam int unsigned MA_W    = 12;
    localparam int unsigned DUTY_W  = 10;
    localparam int unsigned COUNT_W = 16;

    localparam logic [MA_W-1:0]   MAX_CURRENT_RESET = 12'd1500;
    localparam logic [MA_W-1:0]   OPEN_LOAD_RESET   = 12'd10;
    localparam logic [DUTY_W-1:0] PWM_MAX_RESET     = 10'd1000;

    // mv * 1200 / 1000 as multiply by scaled reciprocal
    localparam int unsigned CUR_SHIFT  = 18;
    localparam int unsigned CUR_RCP_W  = 19;
    localparam logic [CUR_RCP_W-1:0] CUR_RECIP =
        CUR_RCP_W'((1200 * (2 ** CUR_SHIFT) + 999) / 1000);
    localparam int unsigned CUR_PROD_W = MA_W + CUR_RCP_W;

    // max * 110 / 100 as multiply by scaled reciprocal
    localparam int unsigned SC_SHIFT  = 19;
    localparam int unsigned SC_RCP_W  = 20;
    localparam logic [SC_RCP_W-1:0] SC_RECIP =
        SC_RCP_W'((110 * (2 ** SC_SHIFT) + 99) / 100);
    localparam int unsigned SC_PROD_W = MA_W + SC_RCP_W;
    localparam int unsigned SC_TH_W   = SC_PROD_W - SC_SHIFT;

    localparam logic [3:0] OP_ON          = 4'd0;
    localparam logic [3:0] OP_OFF         = 4'd1;
    localparam logic [3:0] OP_TOGGLE      = 4'd2;
    localparam logic [3:0] OP_SET_DUTY    = 4'd3;
    localparam logic [3:0] OP_DIAGNOSE    = 4'd4;
    localparam logic [3:0] OP_CLEAR_FAULT = 4'd5;
    localparam logic [3:0] OP_ENABLE_ALL  = 4'd6;
    localparam logic [3:0] OP_DISABLE_ALL = 4'd7;
    localparam logic [3:0] OP_SAFE_STATE  = 4'd8;
    localparam logic [3:0] OP_SET_LIMIT   = 4'd9;

    localparam logic [1:0] CFG_MAX_CURRENT = 2'd0;
    localparam logic [1:0] CFG_OPEN_LOAD   = 2'd1;
    localparam logic [1:0] CFG_PWM_MAX     = 2'd2;

    localparam int unsigned FLAG_OC = 0;
    localparam int unsigned FLAG_OL = 1;
    localparam int unsigned FLAG_SC = 2;

    typedef enum logic [1:0] {
        MODE_OFF   = 2'd0,
        MODE_ON    = 2'd1,
        MODE_PWM   = 2'd2,
        MODE_FAULT = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_OC   = 2'd1,
        KIND_OL   = 2'd2,
        KIND_SC   = 2'd3
    } t_kind;

    typedef struct packed {
        logic [3:0]        opcode;
        logic [4:0]        channel;
        logic [DUTY_W-1:0] duty;
        logic [MA_W-1:0]   sense_mv;
        logic [MA_W-1:0]   new_limit;
    } t_cmd;

    typedef struct packed {
        logic               status;
        logic [1:0]         channel_state;
        logic [19:0]        drive_mask;
        logic [1:0]         fault_kind;
        logic               overcurrent;
        logic               open_load;
        logic               short_circuit;
        logic [MA_W-1:0]    meas_current;
        logic [COUNT_W-1:0] channel_faults;
        logic [COUNT_W-1:0] device_faults;
    } t_result;

    typedef struct packed {
        logic              valid;
        logic [3:0]        opcode;
        logic [4:0]        channel;
        logic [DUTY_W-1:0] duty;
        logic [MA_W-1:0]   new_limit;
        logic [MA_W-1:0]   meas_current;
    } t_exec;

    typedef struct packed {
        logic [MA_W-1:0]    max_current;
        logic [MA_W-1:0]    open_load;
        logic [DUTY_W-1:0]  pwm_max;
        logic [SC_TH_W-1:0] short_th;
    } t_cfg;

endpackage

`default_nettype wire

@@ rtl/core/hssc_cmd_reg.sv @@
// ----------------------------------------------------------------------------
// switch channel monitor command register
// captures an accepted command and converts the sense voltage to mA
// ----------------------------------------------------------------------------
`default_nettype none

module hssc_cmd_reg (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_accept,
    input  wire hssc_pkg::t_cmd i_cmd,
    output hssc_pkg::t_exec     o_exec
);
    import hssc_pkg::*;

    logic                  r_valid;
    logic [3:0]            r_opcode;
    logic [4:0]            r_channel;
    logic [DUTY_W-1:0]     r_duty;
    logic [MA_W-1:0]       r_limit;
    logic [MA_W-1:0]       r_current;
    logic [MA_W-1:0]       n_current;
    logic [CUR_PROD_W-1:0] w_prod;
    logic [CUR_PROD_W-CUR_SHIFT-1:0] w_quot;

    always_comb begin
        w_prod = CUR_PROD_W'(i_cmd.sense_mv) * CUR_PROD_W'(CUR_RECIP);
        w_quot = w_prod[CUR_PROD_W-1:CUR_SHIFT];
        if (w_quot > (CUR_PROD_W-CUR_SHIFT)'({MA_W{1'b1}})) begin
            n_current = {MA_W{1'b1}};
        end else begin
            n_current = w_quot[MA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_opcode  <= i_cmd.opcode;
            r_channel <= i_cmd.channel;
            r_duty    <= i_cmd.duty;
            r_limit   <= i_cmd.new_limit;
            r_current <= n_current;
        end
    end

    assign o_exec = '{valid: r_valid, opcode: r_opcode, channel: r_channel,
                      duty: r_duty, new_limit: r_limit, meas_current: r_current};

endmodule

`default_nettype wire

@@ rtl/core/hssc_chan_ctrl.sv @@
// ----------------------------------------------------------------------------
// switch channel monitor channel control
// per-channel state, command execution and result assembly
// ----------------------------------------------------------------------------
`default_nettype none

module hssc_chan_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire hssc_pkg::t_exec i_exec,
    input  wire hssc_pkg::t_cfg  i_cfg,
    output hssc_pkg::t_result    o_res
);
    import hssc_pkg::*;

    t_mode              r_mode      [NUM_CHANNELS];
    logic               r_enabled   [NUM_CHANNELS];
    logic [DUTY_W-1:0]  r_duty      [NUM_CHANNELS];
    logic [MA_W-1:0]    r_limit     [NUM_CHANNELS];
    logic [2:0]         r_flags     [NUM_CHANNELS];
    t_kind              r_kind      [NUM_CHANNELS];
    logic [MA_W-1:0]    r_current   [NUM_CHANNELS];
    logic [COUNT_W-1:0] r_ch_cnt    [NUM_CHANNELS];
    logic [COUNT_W-1:0] r_dev_cnt   [NUM_DEVICES];
    logic [NUM_CHANNELS-1:0] r_drive;

    t_mode              n_mode      [NUM_CHANNELS];
    logic               n_enabled   [NUM_CHANNELS];
    logic [DUTY_W-1:0]  n_duty      [NUM_CHANNELS];
    logic [MA_W-1:0]    n_limit     [NUM_CHANNELS];
    logic [2:0]         n_flags     [NUM_CHANNELS];
    t_kind              n_kind      [NUM_CHANNELS];
    logic [MA_W-1:0]    n_current   [NUM_CHANNELS];
    logic [COUNT_W-1:0] n_ch_cnt    [NUM_CHANNELS];
    logic [COUNT_W-1:0] n_dev_cnt   [NUM_DEVICES];
    logic [NUM_CHANNELS-1:0] n_drive;

    logic                 w_ch_ok;
    logic [CH_IDX_W-1:0]  w_idx;
    logic [DEV_IDX_W-1:0] w_dev;
    logic                 w_status;
    logic                 w_turn_on;
    logic                 w_turn_off;
    logic                 w_oc;
    logic                 w_ol;
    logic                 w_sc;
    logic [1:0]           w_nfaults;

    function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] cnt,
                                                   input logic [1:0] inc);
        logic [COUNT_W:0] sum;
        sum = {1'b0, cnt} + (COUNT_W+1)'(inc);
        if (sum[COUNT_W]) begin
            sat_add = {COUNT_W{1'b1}};
        end else begin
            sat_add = sum[COUNT_W-1:0];
        end
    endfunction

    always_comb begin
        w_ch_ok = i_exec.channel < 5'(NUM_CHANNELS);
        w_idx   = i_exec.channel[CH_IDX_W-1:0];
        w_dev   = DEV_IDX_W'(i_exec.channel / CHANNELS_PER_DEVICE);
        w_oc    = i_exec.meas_current > r_limit[w_idx];
        w_ol    = (r_mode[w_idx] == MODE_ON) && (i_exec.meas_current < i_cfg.open_load);
        w_sc    = SC_TH_W'(i_exec.meas_current) > i_cfg.short_th;
        w_nfaults = 2'(w_oc) + 2'(w_ol) + 2'(w_sc);

        n_mode    = r_mode;
        n_enabled = r_enabled;
        n_duty    = r_duty;
        n_limit   = r_limit;
        n_flags   = r_flags;
        n_kind    = r_kind;
        n_current = r_current;
        n_ch_cnt  = r_ch_cnt;
        n_dev_cnt = r_dev_cnt;
        n_drive   = r_drive;
        w_status   = 1'b0;
        w_turn_on  = 1'b0;
        w_turn_off = 1'b0;

        if (i_exec.valid) begin
            case (i_exec.opcode)
                OP_ON: begin
                    w_status  = !w_ch_ok;
                    w_turn_on = w_ch_ok;
                end
                OP_OFF: begin
                    w_status   = !w_ch_ok;
                    w_turn_off = w_ch_ok;
                end
                OP_TOGGLE: begin
                    w_status   = !w_ch_ok;
                    w_turn_off = w_ch_ok && (r_mode[w_idx] == MODE_ON);
                    w_turn_on  = w_ch_ok && (r_mode[w_idx] != MODE_ON);
                end
                OP_SET_DUTY: begin
                    if (!w_ch_ok || (i_exec.duty > i_cfg.pwm_max)) begin
                        w_status = 1'b1;
                    end else begin
                        n_duty[w_idx] = i_exec.duty;
                        if (i_exec.duty == '0) begin
                            n_mode[w_idx]  = MODE_OFF;
                            n_drive[w_idx] = 1'b0;
                        end else if (i_exec.duty == i_cfg.pwm_max) begin
                            n_mode[w_idx]  = MODE_ON;
                            n_drive[w_idx] = 1'b1;
                        end else begin
                            n_mode[w_idx]  = MODE_PWM;
                            n_drive[w_idx] = 1'b1;
                        end
                    end
                end
                OP_DIAGNOSE: begin
                    if (!w_ch_ok) begin
                        w_status = 1'b1;
                    end else begin
                        n_current[w_idx] = i_exec.meas_current;
                        n_flags[w_idx]   = '0;
                        n_flags[w_idx][FLAG_OC] = w_oc;
                        n_flags[w_idx][FLAG_OL] = w_ol;
                        n_flags[w_idx][FLAG_SC] = w_sc;
                        if (w_sc) begin
                            n_kind[w_idx]  = KIND_SC;
                            n_mode[w_idx]  = MODE_FAULT;
                            n_drive[w_idx] = 1'b0;
                        end else if (w_ol) begin
                            n_kind[w_idx] = KIND_OL;
                        end else if (w_oc) begin
                            n_kind[w_idx] = KIND_OC;
                        end
                        n_ch_cnt[w_idx]  = sat_add(r_ch_cnt[w_idx], w_nfaults);
                        n_dev_cnt[w_dev] = sat_add(r_dev_cnt[w_dev], w_nfaults);
                    end
                end
                OP_CLEAR_FAULT: begin
                    if (!w_ch_ok) begin
                        w_status = 1'b1;
                    end else begin
                        n_kind[w_idx]  = KIND_NONE;
                        n_flags[w_idx] = '0;
                        if (r_mode[w_idx] == MODE_FAULT) begin
                            n_mode[w_idx] = MODE_OFF;
                        end
                    end
                end
                OP_ENABLE_ALL: begin
                    for (int i = 0; i < NUM_CHANNELS; i++) begin
                        if (r_enabled[i]) begin
                            n_mode[i]  = MODE_ON;
                            n_drive[i] = 1'b1;
                        end
                    end
                end
                OP_DISABLE_ALL: begin
                    n_drive = '0;
                    for (int i = 0; i < NUM_CHANNELS; i++) begin
                        if (r_mode[i] == MODE_ON) begin
                            n_mode[i] = MODE_OFF;
                        end
                    end
                end
                OP_SAFE_STATE: begin
                    n_drive = '0;
                    for (int i = 0; i < NUM_CHANNELS; i++) begin
                        n_mode[i] = MODE_OFF;
                    end
                end
                OP_SET_LIMIT: begin
                    if (!w_ch_ok || (i_exec.new_limit > i_cfg.max_current)) begin
                        w_status = 1'b1;
                    end else begin
                        n_limit[w_idx] = i_exec.new_limit;
                    end
                end
                default: begin
                    w_status = 1'b1;
                end
            endcase

            if (w_turn_on) begin
                n_mode[w_idx]    = MODE_ON;
                n_enabled[w_idx] = 1'b1;
                n_duty[w_idx]    = i_cfg.pwm_max;
                n_drive[w_idx]   = 1'b1;
            end
            if (w_turn_off) begin
                n_mode[w_idx]    = MODE_OFF;
                n_enabled[w_idx] = 1'b0;
                n_duty[w_idx]    = '0;
                n_drive[w_idx]   = 1'b0;
            end
        end
    end

    always_comb begin
        o_res            = '0;
        o_res.status     = w_status;
        o_res.drive_mask = n_drive;
        if (w_ch_ok) begin
            o_res.channel_state  = n_mode[w_idx];
            o_res.fault_kind     = n_kind[w_idx];
            o_res.overcurrent    = n_flags[w_idx][FLAG_OC];
            o_res.open_load      = n_flags[w_idx][FLAG_OL];
            o_res.short_circuit  = n_flags[w_idx][FLAG_SC];
            o_res.meas_current   = n_current[w_idx];
            o_res.channel_faults = n_ch_cnt[w_idx];
            o_res.device_faults  = n_dev_cnt[w_dev];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_mode[i]    <= MODE_OFF;
                r_enabled[i] <= 1'b0;
                r_duty[i]    <= '0;
                r_limit[i]   <= MAX_CURRENT_RESET;
                r_flags[i]   <= '0;
                r_kind[i]    <= KIND_NONE;
                r_current[i] <= '0;
                r_ch_cnt[i]  <= '0;
            end
            for (int d = 0; d < NUM_DEVICES; d++) begin
                r_dev_cnt[d] <= '0;
            end
            r_drive <= '0;
        end else begin
            r_mode    <= n_mode;
            r_enabled <= n_enabled;
            r_duty    <= n_duty;
            r_limit   <= n_limit;
            r_flags   <= n_flags;
            r_kind    <= n_kind;
            r_current <= n_current;
            r_ch_cnt  <= n_ch_cnt;
            r_dev_cnt <= n_dev_cnt;
            r_drive   <= n_drive;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/high_side_switch_channel_monitor_core.sv @@
// ----------------------------------------------------------------------------
// switch channel monitor core
// controller and fault monitor for twenty switched output channels
//
//   port group    direction  handshake               payload
//   command       in         i_start / o_busy        i_cmd (hssc_pkg::t_cmd)
//   result        out        o_done strobe           o_res (hssc_pkg::t_result)
//   config write  in         i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// one command per cycle; o_busy stays low and the config port is always ready
// each result is registered in the command register (sense conversion multiply)
// and then in the result register, along with the channel state update
// o_done lasts one cycle; results cannot be held off
// synchronous active-low reset clears all channel state and loads register
// defaults; no clearing pass is needed
// ----------------------------------------------------------------------------
`default_nettype none

`include "high_side_switch_channel_monitor_core_defines.svh"

module high_side_switch_channel_monitor_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    output logic                   o_busy,
    input  wire hssc_pkg::t_cmd    i_cmd,
    output logic                   o_done,
    output hssc_pkg::t_result      o_res,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [1:0]        i_cfg_index,
    input  wire logic [11:0]       i_cfg_data
);
    import hssc_pkg::*;

    logic [MA_W-1:0]    r_max_current;
    logic [MA_W-1:0]    r_open_load;
    logic [DUTY_W-1:0]  r_pwm_max;
    logic [SC_TH_W-1:0] w_short_th;
    logic [SC_PROD_W-1:0] w_sc_prod;
    logic               w_accept;
    logic               w_cfg_wr;
    t_exec              w_exec;
    t_cfg               w_cfg;
    t_result            w_res;
    t_result            r_res;
    logic               r_done;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_start && !o_busy;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_current <= MAX_CURRENT_RESET;
            r_open_load   <= OPEN_LOAD_RESET;
            r_pwm_max     <= PWM_MAX_RESET;
        end else if (w_cfg_wr) begin
            case (i_cfg_index)
                CFG_MAX_CURRENT: r_max_current <= i_cfg_data;
                CFG_OPEN_LOAD:   r_open_load   <= i_cfg_data;
                CFG_PWM_MAX:     r_pwm_max     <= i_cfg_data[DUTY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // short threshold derived from the rated current
    assign w_sc_prod  = SC_PROD_W'(r_max_current) * SC_PROD_W'(SC_RECIP);
    assign w_short_th = w_sc_prod[SC_PROD_W-1:SC_SHIFT];

    assign w_cfg = '{max_current: r_max_current, open_load: r_open_load,
                     pwm_max: r_pwm_max, short_th: w_short_th};

    hssc_cmd_reg u_cmd_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_cmd    (i_cmd),
        .o_exec   (w_exec)
    );

    hssc_chan_ctrl u_chan_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_exec  (w_exec),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_exec.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exec.valid) begin
            r_res <= w_res;
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

    `HSSC_ASSERT_NEXT(a_accept_to_exec, i_clk, i_rst_n, w_accept, w_exec.valid)
    `HSSC_ASSERT_NEXT(a_exec_to_done, i_clk, i_rst_n, w_exec.valid, o_done)
    `HSSC_ASSERT_NEXT(a_safe_drive_off, i_clk, i_rst_n, w_exec.valid && (w_exec.opcode == OP_SAFE_STATE || w_exec.opcode == OP_DISABLE_ALL), o_res.drive_mask == '0)
    `HSSC_ASSERT_NEXT(a_bad_opcode_status, i_clk, i_rst_n, w_exec.valid && (w_exec.opcode > OP_SET_LIMIT), o_res.status)

endmodule

`default_nettype wire

@@ verif/tb_high_side_switch_channel_monitor_core.sv @@
// ----------------------------------------------------------------------------
// switch channel monitor core testbench
// drives directed and random commands through the command port, changes the
// current and duty registers between phases, and checks every result against
// a cycle-free prediction of channel modes, drive bits, diagnosis and counts
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_high_side_switch_channel_monitor_core;

    import hssc_pkg::*;

    localparam logic [3:0] OP_UNDEF_LO      = 4'd10;
    localparam logic [3:0] OP_UNDEF_HI      = 4'd15;
    localparam int         PHASE_ITEMS      = 155;
    localparam int         FAULT_PAIRS      = 20;
    localparam int         FAULT_CH         = 1;
    localparam int         SETTLE_CYCLES    = 4;
    localparam int         MAX_REPORTS      = 100;

    // tracks channel state and predicts the result of every command
    class switch_bank_tracker;
        logic [MA_W-1:0]    max_current;
        logic [MA_W-1:0]    open_load;
        logic [DUTY_W-1:0]  pwm_max;
        t_mode              chan_mode [NUM_CHANNELS];
        bit                 chan_enabled [NUM_CHANNELS];
        logic [DUTY_W-1:0]  chan_duty [NUM_CHANNELS];
        logic [MA_W-1:0]    chan_limit [NUM_CHANNELS];
        logic [2:0]         chan_flags [NUM_CHANNELS];
        t_kind              chan_kind [NUM_CHANNELS];
        logic [MA_W-1:0]    chan_current [NUM_CHANNELS];
        logic [COUNT_W-1:0] chan_fault_count [NUM_CHANNELS];
        logic [COUNT_W-1:0] dev_fault_count [NUM_DEVICES];
        logic [19:0]        drive_bits;
        t_result            pending_results [$];
        int                 commands;
        int                 rejects;
        int                 flagged_diagnoses;
        int                 checked;
        int                 mismatches;

        function new();
            max_current = MAX_CURRENT_RESET;
            open_load   = OPEN_LOAD_RESET;
            pwm_max     = PWM_MAX_RESET;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                chan_mode[i]        = MODE_OFF;
                chan_enabled[i]     = 1'b0;
                chan_duty[i]        = '0;
                chan_limit[i]       = MAX_CURRENT_RESET;
                chan_flags[i]       = '0;
                chan_kind[i]        = KIND_NONE;
                chan_current[i]     = '0;
                chan_fault_count[i] = '0;
            end
            for (int d = 0; d < NUM_DEVICES; d++) begin
                dev_fault_count[d] = '0;
            end
            drive_bits        = '0;
            commands          = 0;
            rejects           = 0;
            flagged_diagnoses = 0;
            checked           = 0;
            mismatches        = 0;
        endfunction

        function void write_register(logic [1:0] idx, logic [11:0] data);
            case (idx)
                CFG_MAX_CURRENT: max_current = data;
                CFG_OPEN_LOAD:   open_load   = data;
                CFG_PWM_MAX:     pwm_max     = data[DUTY_W-1:0];
                default: ;
            endcase
        endfunction

        function void set_drive(int unsigned ch, bit on);
            drive_bits[ch] = on;
        endfunction

        function void switch_on(int unsigned ch);
            chan_mode[ch]    = MODE_ON;
            chan_enabled[ch] = 1'b1;
            chan_duty[ch]    = pwm_max;
            set_drive(ch, 1'b1);
        endfunction

        function void switch_off(int unsigned ch);
            chan_mode[ch]    = MODE_OFF;
            chan_enabled[ch] = 1'b0;
            chan_duty[ch]    = '0;
            set_drive(ch, 1'b0);
        endfunction

        function void count_fault(int unsigned ch);
            int unsigned dev;
            dev = ch / CHANNELS_PER_DEVICE;
            if (chan_fault_count[ch] != '1) chan_fault_count[ch]++;
            if (dev < NUM_DEVICES && dev_fault_count[dev] != '1) dev_fault_count[dev]++;
        endfunction

        function void note_command(t_cmd c);
            t_result     r;
            int unsigned ch;
            int unsigned cur;
            int unsigned short_th;
            bit          in_range;
            bit          rejected;
            ch       = 32'(c.channel);
            in_range = (ch < NUM_CHANNELS);
            rejected = 1'b0;
            commands++;
            case (c.opcode)
                OP_ENABLE_ALL: begin
                    for (int i = 0; i < NUM_CHANNELS; i++) begin
                        if (chan_enabled[i]) begin
                            chan_mode[i] = MODE_ON;
                            set_drive(i, 1'b1);
                        end
                    end
                end
                OP_DISABLE_ALL: begin
                    drive_bits = '0;
                    for (int i = 0; i < NUM_CHANNELS; i++) begin
                        if (chan_mode[i] == MODE_ON) chan_mode[i] = MODE_OFF;
                    end
                end
                OP_SAFE_STATE: begin
                    drive_bits = '0;
                    for (int i = 0; i < NUM_CHANNELS; i++) chan_mode[i] = MODE_OFF;
                end
                OP_ON, OP_OFF, OP_TOGGLE, OP_SET_DUTY, OP_DIAGNOSE, OP_CLEAR_FAULT,
                OP_SET_LIMIT: begin
                    if (!in_range) begin
                        rejected = 1'b1;
                    end else begin
                        case (c.opcode)
                            OP_ON:  switch_on(ch);
                            OP_OFF: switch_off(ch);
                            OP_TOGGLE: begin
                                if (chan_mode[ch] == MODE_ON) switch_off(ch);
                                else switch_on(ch);
                            end
                            OP_SET_DUTY: begin
                                if (c.duty > pwm_max) begin
                                    rejected = 1'b1;
                                end else begin
                                    chan_duty[ch] = c.duty;
                                    if (c.duty == 0) begin
                                        chan_mode[ch] = MODE_OFF;
                                        set_drive(ch, 1'b0);
                                    end else if (c.duty == pwm_max) begin
                                        chan_mode[ch] = MODE_ON;
                                        set_drive(ch, 1'b1);
                                    end else begin
                                        chan_mode[ch] = MODE_PWM;
                                        set_drive(ch, 1'b1);
                                    end
                                end
                            end
                            OP_DIAGNOSE: begin
                                cur      = (32'(c.sense_mv) * 1200) / 1000;
                                short_th = (32'(max_current) * 110) / 100;
                                if (cur > 4095) cur = 4095;
                                chan_current[ch] = cur[MA_W-1:0];
                                if (cur > chan_limit[ch]) begin
                                    chan_flags[ch][FLAG_OC] = 1'b1;
                                    chan_kind[ch] = KIND_OC;
                                    count_fault(ch);
                                end else begin
                                    chan_flags[ch][FLAG_OC] = 1'b0;
                                end
                                if (chan_mode[ch] == MODE_ON && cur < open_load) begin
                                    chan_flags[ch][FLAG_OL] = 1'b1;
                                    chan_kind[ch] = KIND_OL;
                                    count_fault(ch);
                                end else begin
                                    chan_flags[ch][FLAG_OL] = 1'b0;
                                end
                                if (cur > short_th) begin
                                    chan_flags[ch][FLAG_SC] = 1'b1;
                                    chan_kind[ch] = KIND_SC;
                                    count_fault(ch);
                                    chan_mode[ch] = MODE_FAULT;
                                    set_drive(ch, 1'b0);
                                end else begin
                                    chan_flags[ch][FLAG_SC] = 1'b0;
                                end
                                if (chan_flags[ch] != 0) flagged_diagnoses++;
                            end
                            OP_CLEAR_FAULT: begin
                                chan_kind[ch]  = KIND_NONE;
                                chan_flags[ch] = '0;
                                if (chan_mode[ch] == MODE_FAULT) chan_mode[ch] = MODE_OFF;
                            end
                            default: begin
                                if (c.new_limit > max_current) rejected = 1'b1;
                                else chan_limit[ch] = c.new_limit;
                            end
                        endcase
                    end
                end
                default: rejected = 1'b1;
            endcase
            if (rejected) rejects++;
            r            = '0;
            r.status     = rejected;
            r.drive_mask = drive_bits;
            if (in_range) begin
                r.channel_state  = chan_mode[ch];
                r.fault_kind     = chan_kind[ch];
                r.overcurrent    = chan_flags[ch][FLAG_OC];
                r.open_load      = chan_flags[ch][FLAG_OL];
                r.short_circuit  = chan_flags[ch][FLAG_SC];
                r.meas_current   = chan_current[ch];
                r.channel_faults = chan_fault_count[ch];
                r.device_faults  = dev_fault_count[ch / CHANNELS_PER_DEVICE];
            end
            pending_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                if (mismatches < MAX_REPORTS) begin
                    $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                end
                mismatches++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                $error("result transaction with no command outstanding");
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            checked++;
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("channel_state", 32'(want.channel_state),
                          32'(got.channel_state));
            compare_field("drive_mask", 32'(want.drive_mask), 32'(got.drive_mask));
            compare_field("fault_kind", 32'(want.fault_kind), 32'(got.fault_kind));
            compare_field("overcurrent", 32'(want.overcurrent), 32'(got.overcurrent));
            compare_field("open_load", 32'(want.open_load), 32'(got.open_load));
            compare_field("short_circuit", 32'(want.short_circuit),
                          32'(got.short_circuit));
            compare_field("meas_current", 32'(want.meas_current), 32'(got.meas_current));
            compare_field("channel_faults", 32'(want.channel_faults),
                          32'(got.channel_faults));
            compare_field("device_faults", 32'(want.device_faults),
                          32'(got.device_faults));
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    t_cmd        i_cmd;
    logic        o_done;
    t_result     o_res;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [11:0] i_cfg_data;

    switch_bank_tracker sb;
    int                 settings_applied;

    high_side_switch_channel_monitor_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_cmd       (i_cmd),
        .o_done      (o_done),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) sb.check_result(o_res);
            if (i_start && !o_busy) sb.note_command(i_cmd);
            if (i_cfg_valid && o_cfg_ready) sb.write_register(i_cfg_index, i_cfg_data);
        end
    end

    function automatic t_cmd make_cmd(logic [3:0] op, int unsigned ch, int unsigned duty,
                                      int unsigned mv, int unsigned lim);
        t_cmd c;
        c.opcode    = op;
        c.channel   = 5'(ch);
        c.duty      = DUTY_W'(duty);
        c.sense_mv  = MA_W'(mv);
        c.new_limit = MA_W'(lim);
        return c;
    endfunction

    function automatic t_cmd random_command();
        t_cmd        c;
        int unsigned pick;
        int unsigned target;
        int unsigned lim_ref;
        bit          aim;
        int          mv;
        c    = t_cmd'({$urandom, $urandom});
        pick = $urandom_range(0, 99);
        if (pick < 10)      c.opcode = OP_ON;
        else if (pick < 16) c.opcode = OP_OFF;
        else if (pick < 24) c.opcode = OP_TOGGLE;
        else if (pick < 35) c.opcode = OP_SET_DUTY;
        else if (pick < 65) c.opcode = OP_DIAGNOSE;
        else if (pick < 72) c.opcode = OP_CLEAR_FAULT;
        else if (pick < 75) c.opcode = OP_ENABLE_ALL;
        else if (pick < 78) c.opcode = OP_DISABLE_ALL;
        else if (pick < 80) c.opcode = OP_SAFE_STATE;
        else if (pick < 93) c.opcode = OP_SET_LIMIT;
        else                c.opcode = 4'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
        if ($urandom_range(0, 99) < 88) c.channel = 5'($urandom_range(0, NUM_CHANNELS - 1));
        else c.channel = 5'($urandom_range(NUM_CHANNELS, 31));
        case ($urandom_range(0, 4))
            0: c.duty = '0;
            1: c.duty = sb.pwm_max;
            2: c.duty = (sb.pwm_max == '1) ? sb.pwm_max : sb.pwm_max + 1'b1;
            3: c.duty = DUTY_W'($urandom_range(1, sb.pwm_max));
            default: ;
        endcase
        // aim the sense sample at the thresholds of the addressed channel
        lim_ref = (c.channel < NUM_CHANNELS) ? 32'(sb.chan_limit[c.channel])
                                             : 32'(sb.max_current);
        aim     = 1'b1;
        target  = 0;
        case ($urandom_range(0, 4))
            0: target = lim_ref;
            1: target = 32'(sb.open_load);
            2: target = (32'(sb.max_current) * 110) / 100;
            3: target = $urandom_range(0, 15);
            default: aim = 1'b0;
        endcase
        if (aim) begin
            mv = int'(target * 1000 / 1200) + int'($urandom_range(0, 6)) - 3;
            if (mv < 0) mv = 0;
            if (mv > 4095) mv = 4095;
            c.sense_mv = MA_W'(mv);
        end
        case ($urandom_range(0, 3))
            0: c.new_limit = MA_W'($urandom_range(0, sb.max_current));
            1: c.new_limit = sb.max_current;
            2: c.new_limit = (sb.max_current == '1) ? sb.max_current : sb.max_current + 1'b1;
            default: ;
        endcase
        return c;
    endfunction

    // all driving tasks start and end at a falling edge
    task automatic send_cmd(input t_cmd c);
        i_start <= 1'b1;
        i_cmd   <= c;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic idle_cycles(input int n);
        i_start <= 1'b0;
        i_cmd   <= t_cmd'({$urandom, $urandom});
        repeat (n) @(negedge i_clk);
    endtask

    task automatic drain();
        idle_cycles(1);
        while (sb.pending_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic apply_settings(input int unsigned max_ma, input int unsigned open_ma,
                                  input int unsigned pwm);
        logic [1:0]  idx [3];
        int unsigned val [3];
        idx = '{CFG_MAX_CURRENT, CFG_OPEN_LOAD, CFG_PWM_MAX};
        val = '{max_ma, open_ma, pwm};
        drain();
        for (int k = 0; k < 3; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= 12'(val[k]);
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= 12'($urandom);
        @(negedge i_clk);
        settings_applied++;
    endtask

    task automatic run_random(input int n);
        int sent;
        int burst;
        sent = 0;
        while (sent < n) begin
            burst = $urandom_range(1, 16);
            for (int k = 0; k < burst && sent < n; k++) begin
                send_cmd(random_command());
                sent++;
            end
            if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 6));
        end
    endtask

    initial begin
        sb               = new();
        settings_applied = 0;
        i_rst_n          = 1'b0;
        i_start          = 1'b0;
        i_cmd            = '0;
        i_cfg_valid      = 1'b0;
        i_cfg_index      = '0;
        i_cfg_data       = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed commands under the reset register values
        send_cmd(make_cmd(OP_DIAGNOSE, 0, 0, 0, 0));
        send_cmd(make_cmd(OP_ON, 0, 0, 0, 0));
        send_cmd(make_cmd(OP_DIAGNOSE, 0, 0, 0, 0));
        send_cmd(make_cmd(OP_DIAGNOSE, 0, 0, 4095, 0));
        send_cmd(make_cmd(OP_TOGGLE, 0, 0, 0, 0));
        send_cmd(make_cmd(OP_TOGGLE, 0, 0, 0, 0));
        send_cmd(make_cmd(OP_SET_DUTY, 1, 0, 0, 0));
        send_cmd(make_cmd(OP_SET_DUTY, 1, 1000, 0, 0));
        send_cmd(make_cmd(OP_SET_DUTY, 1, 500, 0, 0));
        send_cmd(make_cmd(OP_SET_DUTY, 1, 1001, 0, 0));
        send_cmd(make_cmd(OP_SET_DUTY, 1, 1023, 0, 0));
        send_cmd(make_cmd(OP_SET_LIMIT, 2, 0, 0, 1501));
        send_cmd(make_cmd(OP_SET_LIMIT, 2, 0, 0, 4095));
        send_cmd(make_cmd(OP_SET_LIMIT, 2, 0, 0, 0));
        send_cmd(make_cmd(OP_DIAGNOSE, 2, 0, 1, 0));
        send_cmd(make_cmd(OP_CLEAR_FAULT, 2, 0, 0, 0));
        send_cmd(make_cmd(OP_ON, 19, 0, 0, 0));
        send_cmd(make_cmd(OP_DIAGNOSE, 19, 0, 1400, 0));
        send_cmd(make_cmd(OP_CLEAR_FAULT, 19, 0, 0, 0));
        send_cmd(make_cmd(OP_ENABLE_ALL, 31, 0, 0, 0));
        send_cmd(make_cmd(OP_DISABLE_ALL, 20, 0, 0, 0));
        send_cmd(make_cmd(OP_ON, 3, 0, 0, 0));
        send_cmd(make_cmd(OP_SAFE_STATE, 0, 0, 0, 0));
        send_cmd(make_cmd(OP_ON, 25, 0, 0, 0));
        send_cmd(make_cmd(OP_DIAGNOSE, 31, 0, 4095, 0));
        send_cmd(make_cmd(OP_UNDEF_HI, 3, 0, 0, 0));
        send_cmd(make_cmd(OP_UNDEF_LO, 21, 0, 0, 0));
        run_random(PHASE_ITEMS);

        apply_settings(4095, 0, 1023);
        run_random(PHASE_ITEMS);
        apply_settings(0, 4095, 1);
        run_random(PHASE_ITEMS);
        for (int p = 0; p < 4; p++) begin
            apply_settings($urandom_range(0, 4095), $urandom_range(0, 400),
                           $urandom_range(1, 1023));
            run_random(PHASE_ITEMS);
        end

        // every diagnosis below raises all three faults at once
        apply_settings(0, 4095, 1023);
        send_cmd(make_cmd(OP_SET_LIMIT, FAULT_CH, 0, 0, 0));
        for (int k = 0; k < FAULT_PAIRS; k++) begin
            send_cmd(make_cmd(OP_ON, FAULT_CH, 0, 0, 0));
            send_cmd(make_cmd(OP_DIAGNOSE, FAULT_CH, 0, 1, 0));
        end
        drain();

        $display("checked %0d results of %0d commands: %0d rejected, %0d diagnoses flagged",
                 sb.checked, sb.commands, sb.rejects, sb.flagged_diagnoses);
        $display("%0d register settings applied, triple faults repeated on channel %0d",
                 settings_applied, FAULT_CH);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #400_000;
        $display("timeout waiting for results");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
